/* rtl/byte_string_escaper_core_macros.svh */
// Assertion macros used by the escaper top level.
`ifndef BYTE_STRING_ESCAPER_CORE_MACROS_SVH
`define BYTE_STRING_ESCAPER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/bse_pkg.sv */
// Package: types, constants and helpers of the byte string escaper.
package bse_pkg;

  localparam logic [6:0] ChQuote  = 7'h22;
  localparam logic [6:0] ChBslash = 7'h5C;
  localparam logic [6:0] ChX      = 7'h78;
  localparam logic [6:0] ChU      = 7'h75;
  localparam logic [6:0] ChZero   = 7'h30;
  localparam logic [6:0] ChB      = 7'h62;
  localparam logic [6:0] ChF      = 7'h66;
  localparam logic [6:0] ChN      = 7'h6E;
  localparam logic [6:0] ChR      = 7'h72;
  localparam logic [6:0] ChT      = 7'h74;
  localparam logic [7:0] PrintLo  = 8'h20;
  localparam logic [7:0] PrintEnd = 8'h7F;

  localparam logic StyleHex     = 1'b0;
  localparam logic RegEscStyle  = 1'b0;

  localparam int BodySlots = 8;
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  // One queued request: leading quotes, body characters, optional closing quote.
  typedef struct packed {
    logic [1:0]                pre_cnt;
    logic [2:0]                body_len;
    logic                      close;
    logic [BodySlots-1:0][6:0] body;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic push;
    logic pop;
  } q_stat_t;

  function automatic logic [6:0] hex_upper(input logic [3:0] v);
    logic [6:0] r;
    if (v < 4'd10) r = ChZero + {3'b0, v};
    else r = 7'h41 + {3'b0, v} - 7'd10;
    return r;
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

endpackage

/* rtl/bse_if.sv */
// Stream interfaces for input bytes and output characters.
interface bse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface bse_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_of_run;
  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

/* rtl/bse_front.sv */
// Front end: accepts bytes, classifies them and builds emit requests.
module bse_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           style_i,
  input  logic           q_full_i,
  output logic           push_o,
  output bse_pkg::desc_t desc_o,
  output logic           pending_o,
  bse_in_if.sink         in_if
);

  logic       pending_q, pending_d;
  logic       is_esc, printable, hex_esc, brk, accept;
  logic [6:0] esc_ch;
  logic [7:0] b;

  assign b         = in_if.data_byte;
  assign in_if.ready = !q_full_i;
  assign accept    = in_if.valid && in_if.ready;
  assign push_o    = accept;
  assign pending_o = pending_q;

  always_comb begin
    unique case (b)
      8'h22:   esc_ch = bse_pkg::ChQuote;
      8'h5C:   esc_ch = bse_pkg::ChBslash;
      8'h08:   esc_ch = bse_pkg::ChB;
      8'h0C:   esc_ch = bse_pkg::ChF;
      8'h0A:   esc_ch = bse_pkg::ChN;
      8'h0D:   esc_ch = bse_pkg::ChR;
      8'h09:   esc_ch = bse_pkg::ChT;
      default: esc_ch = '0;
    endcase
  end

  assign is_esc    = (esc_ch != '0);
  assign printable = (b >= bse_pkg::PrintLo) && (b < bse_pkg::PrintEnd);
  assign hex_esc   = !is_esc && !printable && (style_i == bse_pkg::StyleHex);
  // break quotes only inside a string, never right after an opening quote
  assign brk       = pending_q && !in_if.first_byte && bse_pkg::is_hex_digit(b);

  always_comb begin
    desc_o         = '0;
    desc_o.pre_cnt = in_if.first_byte ? 2'd1 : (brk ? 2'd2 : 2'd0);
    desc_o.close   = in_if.last_byte;
    if (is_esc) begin
      desc_o.body[0]  = bse_pkg::ChBslash;
      desc_o.body[1]  = esc_ch;
      desc_o.body_len = 3'd2;
    end else if (printable) begin
      desc_o.body[0]  = b[6:0];
      desc_o.body_len = 3'd1;
    end else if (style_i == bse_pkg::StyleHex) begin
      desc_o.body[0]  = bse_pkg::ChBslash;
      desc_o.body[1]  = bse_pkg::ChX;
      desc_o.body[2]  = bse_pkg::hex_upper(b[7:4]);
      desc_o.body[3]  = bse_pkg::hex_upper(b[3:0]);
      desc_o.body_len = 3'd4;
    end else begin
      desc_o.body[0]  = bse_pkg::ChBslash;
      desc_o.body[1]  = bse_pkg::ChU;
      desc_o.body[2]  = bse_pkg::ChZero;
      desc_o.body[3]  = bse_pkg::ChZero;
      desc_o.body[4]  = bse_pkg::hex_upper(b[7:4]);
      desc_o.body[5]  = bse_pkg::hex_upper(b[3:0]);
      desc_o.body_len = 3'd6;
    end
  end

  always_comb begin
    pending_d = pending_q;
    if (accept) pending_d = !in_if.last_byte && hex_esc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
    end
  end

endmodule

/* rtl/bse_queue.sv */
// Short request queue between front and back end.
module bse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bse_pkg::desc_t desc_i,
  input  logic           pop_i,
  output bse_pkg::desc_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  bse_pkg::desc_t                 mem_q [bse_pkg::QDepth];
  logic [bse_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [bse_pkg::QCntW-1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == bse_pkg::QCntW'(bse_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) wr_ptr_d = wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = rd_ptr_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= desc_i;
  end

endmodule

/* rtl/bse_back.sv */
// Back end: walks each request and emits one character per cycle while out_if.ready is high.
module bse_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bse_pkg::desc_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  bse_out_if.source      out_if
);

  logic [2:0] idx_q, idx_d, bi;
  logic [3:0] idx4, pb, n;
  logic [6:0] ch;
  logic       is_last, advance, load;
  logic       valid_q, valid_d, last_q;
  logic [6:0] char_q;

  assign idx4    = {1'b0, idx_q};
  assign pb      = {2'b0, head_i.pre_cnt} + {1'b0, head_i.body_len};
  assign n       = pb + {3'b0, head_i.close};
  assign bi      = idx_q - {1'b0, head_i.pre_cnt};
  assign is_last = (idx4 == n - 4'd1);

  always_comb begin
    if (idx4 < {2'b0, head_i.pre_cnt}) ch = bse_pkg::ChQuote;
    else if (idx4 < pb) ch = head_i.body[bi];
    else ch = bse_pkg::ChQuote;
  end

  // output register moves whenever empty or being taken
  assign advance = !valid_q || out_if.ready;
  assign load    = advance && !empty_i;
  assign pop_o   = load && is_last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (advance) valid_d = !empty_i;
    if (load) idx_d = is_last ? 3'd0 : idx_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= ch;
      last_q <= is_last;
    end
  end

  assign out_if.valid       = valid_q;
  assign out_if.out_char    = char_q;
  assign out_if.last_of_run = last_q;

endmodule

/* rtl/byte_string_escaper_core.sv */
// Top level: byte string escaper with APB style register and stream channels.
// The first character of a byte passes through a queue entry and then the output register.
// A byte yields 1..8 characters, emitted one per cycle while out_if.ready is high;
//   printable bytes inside a string thus flow at one per cycle.
// A two-entry request queue lets the front accept while the back end emits.
// Reset (rst_ni low, asynchronous): queue empty, no output valid, style hex, pending clear.
`include "byte_string_escaper_core_macros.svh"
module byte_string_escaper_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  bse_in_if.sink      in_if,
  bse_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             style_q;
  logic             cfg_wr, pending;
  bse_pkg::desc_t   desc, head;
  bse_pkg::q_stat_t q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == bse_pkg::RegEscStyle) ? {31'b0, style_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q <= bse_pkg::StyleHex;
    end else if (cfg_wr && paddr[2] == bse_pkg::RegEscStyle) begin
      style_q <= pwdata[0];
    end
  end

  bse_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .style_i   (style_q),
    .q_full_i  (q_stat.full),
    .push_o    (q_stat.push),
    .desc_o    (desc),
    .pending_o (pending),
    .in_if     (in_if)
  );

  bse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_stat.push),
    .desc_i  (desc),
    .pop_i   (q_stat.pop),
    .head_o  (head),
    .full_o  (q_stat.full),
    .empty_o (q_stat.empty)
  );

  bse_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (q_stat.empty),
    .pop_o   (q_stat.pop),
    .out_if  (out_if)
  );

  `BSE_ASSERT(a_no_overflow, clk_i, rst_ni, q_stat.push |-> !q_stat.full, "queue overflow")
  `BSE_ASSERT(a_pop_marks_last, clk_i, rst_ni, q_stat.pop |=> (out_if.valid && out_if.last_of_run), "pop without last character")
  `BSE_ASSERT(a_last_clears_pending, clk_i, rst_ni, (q_stat.push && in_if.last_byte) |=> !pending, "pending flag survives string end")
  `BSE_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_if.valid, "output valid after reset")

endmodule
